// File: hw/rtl/crmm_pkg.sv
package crmm_pkg;

  // Design limits.
  localparam int MAX_DIM      = 1024;
  localparam int MAX_CHANNELS = 3;

  // Register widths.
  localparam int REG_DIM_W  = 11;
  localparam int CHC_W      = 2;
  localparam int SCALE_W    = 24;
  localparam int MEAN_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_C0       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_C1       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_C2       = 3'd7;

  // Register reset values.
  localparam logic [REG_DIM_W-1:0] RST_SRC_DIM   = 11'd256;
  localparam logic [CHC_W-1:0]     RST_CHANNELS  = 2'd3;
  localparam logic [SCALE_W-1:0]   RST_SCALE     = 24'd65536;

  // Stream field widths.
  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 10;
  localparam int ADDR_W  = 22;
  localparam int VALUE_W = 34;
  localparam int FRAC_W  = 16;
  localparam int MEAN_FRAC_W = 4;

  // Internal widths derived from the limits.
  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CHW_W  = (MAX_CHANNELS * MAX_DIM > 1) ? $clog2(MAX_CHANNELS * MAX_DIM) : 1;
  localparam int DIFF_W = BYTE_W + MEAN_FRAC_W + 1;
  localparam int PROD_W = DIFF_W + SCALE_W + 1;
  localparam int ROUND_SHIFT = 4;
  localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

  // Effective configuration seen by the datapath.
  typedef struct packed {
    logic [DIM_W-1:0]   h_eff;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   k_eff;
    logic [DIM_W-1:0]   win_h;
    logic [DIM_W-1:0]   win_w;
    logic [CNT_W-1:0]   c_eff;
    logic [SCALE_W-1:0] scale;
    logic [MEAN_W-1:0]  mean0;
    logic [MEAN_W-1:0]  mean1;
    logic [MEAN_W-1:0]  mean2;
  } cfg_t;

  // Raster position of one accepted byte with its window settings.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [CH_W-1:0]   chan;
    logic [POS_W-1:0]  row_off;
    logic [POS_W-1:0]  col_off;
    logic              mirror;
    logic              raw;
  } pos_t;

  // A byte that falls inside the window.
  typedef struct packed {
    logic [BYTE_W-1:0]        byte_val;
    logic                     raw;
    logic signed [DIFF_W-1:0] diff;
    logic [CHW_W-1:0]         chw;
    logic [POS_W-1:0]         col_dst;
    logic                     last;
  } win_t;

  // Product stage.
  typedef struct packed {
    logic [BYTE_W-1:0]        byte_val;
    logic                     raw;
    logic signed [PROD_W-1:0] prod;
    logic [ADDR_W-1:0]        addr;
    logic                     last;
  } prod_t;

  // Dimension register with 0 taken as 1 and large values capped.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // Mean of a channel; channels without a register use zero.
  function automatic logic [MEAN_W-1:0] channel_mean(input logic [CH_W-1:0] ch,
                                                     input cfg_t c);
    logic [MEAN_W-1:0] m;
    case (int'(ch))
      0: m = c.mean0;
      1: m = c.mean1;
      2: m = c.mean2;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/crmm_stream_if.sv
interface crmm_pixel_if;
  import crmm_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              image_start;
  logic              mirror_on;
  logic              center_mode;
  logic [OFF_W-1:0]  row_offset;
  logic [OFF_W-1:0]  col_offset;
  logic              raw_mode;

  modport source (
    output valid, pixel_byte, image_start, mirror_on, center_mode,
           row_offset, col_offset, raw_mode,
    input  ready
  );
  modport sink (
    input  valid, pixel_byte, image_start, mirror_on, center_mode,
           row_offset, col_offset, raw_mode,
    output ready
  );
endinterface

interface crmm_result_if;
  import crmm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ADDR_W-1:0]         out_addr;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;

  modport source (
    output valid, out_addr, out_value, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_addr, out_value, out_last,
    output ready
  );
endinterface

// File: hw/rtl/crop_mirror_mean_scale_chw_top.sv
// A byte's result beat goes through the input, window, product and output registers.
// Throughput: one byte per cycle unless the output stalls; out-of-window bytes give no beat.
// The four register stages stall independently, so empty stages still take new bytes.
// Reset (rst, synchronous, active high) loads the register defaults, clears the raster
// position and the latched image settings, and empties every stage.
module crop_mirror_mean_scale_chw_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [crmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crmm_pkg::CFG_DATA_W-1:0] cfg_data,
  crmm_pixel_if.sink                      pixel,
  crmm_result_if.source                   result
);
  import crmm_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  logic s1_ready;
  pos_t s1;
  logic s2_valid;
  logic s2_ready;
  win_t s2;

  // Configuration registers.
  crmm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Raster tracking and input register.
  crmm_track u_track (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pixel    (pixel),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_ready (s1_ready)
  );

  // Window test, mirroring and mean subtraction.
  crmm_win u_win (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_ready (s1_ready),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_ready (s2_ready)
  );

  // Scaling, rounding and address, ending in the output register.
  crmm_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_ready (s2_ready),
    .result   (result)
  );

endmodule

// File: hw/rtl/crmm_cfg.sv
module crmm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [crmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crmm_pkg::CFG_DATA_W-1:0] cfg_data,
  output crmm_pkg::cfg_t                  cfg
);
  import crmm_pkg::*;

  logic [REG_DIM_W-1:0] src_height;
  logic [REG_DIM_W-1:0] src_width;
  logic [REG_DIM_W-1:0] crop_side;
  logic [CHC_W-1:0]     channel_count;
  logic [SCALE_W-1:0]   scale_factor;
  logic [MEAN_W-1:0]    mean_c0;
  logic [MEAN_W-1:0]    mean_c1;
  logic [MEAN_W-1:0]    mean_c2;

  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] side_min;
  logic [DIM_W-1:0] k_eff;

  // Register file write decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_height    <= RST_SRC_DIM;
      src_width     <= RST_SRC_DIM;
      crop_side     <= '0;
      channel_count <= RST_CHANNELS;
      scale_factor  <= RST_SCALE;
      mean_c0       <= '0;
      mean_c1       <= '0;
      mean_c2       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_HEIGHT:    src_height    <= cfg_data[REG_DIM_W-1:0];
        REG_SRC_WIDTH:     src_width     <= cfg_data[REG_DIM_W-1:0];
        REG_CROP_SIZE:     crop_side     <= cfg_data[REG_DIM_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHC_W-1:0];
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data[SCALE_W-1:0];
        REG_MEAN_C0:       mean_c0       <= cfg_data[MEAN_W-1:0];
        REG_MEAN_C1:       mean_c1       <= cfg_data[MEAN_W-1:0];
        REG_MEAN_C2:       mean_c2       <= cfg_data[MEAN_W-1:0];
      endcase
    end
  end

  // Clamped dimensions and the crop side, limited to the smaller image side.
  assign h_eff    = clamp_dim(src_height);
  assign w_eff    = clamp_dim(src_width);
  assign side_min = (h_eff < w_eff) ? h_eff : w_eff;
  assign k_eff    = (crop_side > side_min) ? side_min : DIM_W'(crop_side);

  assign cfg.h_eff = h_eff;
  assign cfg.w_eff = w_eff;
  assign cfg.k_eff = k_eff;
  assign cfg.win_h = (k_eff != '0) ? k_eff : h_eff;
  assign cfg.win_w = (k_eff != '0) ? k_eff : w_eff;
  assign cfg.c_eff = (channel_count == '0) ? CNT_W'(1) :
                     (int'(channel_count) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) :
                     CNT_W'(channel_count);
  assign cfg.scale = scale_factor;
  assign cfg.mean0 = mean_c0;
  assign cfg.mean1 = mean_c1;
  assign cfg.mean2 = mean_c2;

endmodule

// File: hw/rtl/crmm_track.sv
module crmm_track (
  input  logic           clk,
  input  logic           rst,
  input  crmm_pkg::cfg_t cfg,
  crmm_pixel_if.sink     pixel,
  output logic           s1_valid,
  output crmm_pkg::pos_t s1,
  input  logic           s1_ready
);
  import crmm_pkg::*;

  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] col_count;
  logic [CH_W-1:0]  chan_count;
  logic [POS_W-1:0] latched_row_off;
  logic [POS_W-1:0] latched_col_off;
  logic             latched_mirror;
  logic             latched_raw;

  logic             accept;
  logic [DIM_W-1:0] h_room;
  logic [DIM_W-1:0] w_room;
  logic [POS_W-1:0] ro_start;
  logic [POS_W-1:0] co_start;
  logic [POS_W-1:0] r_cur;
  logic [POS_W-1:0] c_cur;
  logic [CH_W-1:0]  ch_cur;
  logic [POS_W-1:0] ro_cur;
  logic [POS_W-1:0] co_cur;
  logic             mirror_cur;
  logic             raw_cur;
  logic [POS_W-1:0] row_next;
  logic [POS_W-1:0] col_next;
  logic [CH_W-1:0]  chan_next;

  assign pixel.ready = !rst && (!s1_valid || s1_ready);
  assign accept      = pixel.valid && pixel.ready;

  // Window offsets for a new image: centered, or supplied and kept inside.
  assign h_room = cfg.h_eff - cfg.k_eff;
  assign w_room = cfg.w_eff - cfg.k_eff;

  always_comb begin
    ro_start = '0;
    co_start = '0;
    if (cfg.k_eff != '0) begin
      if (pixel.center_mode) begin
        ro_start = POS_W'(h_room >> 1);
        co_start = POS_W'(w_room >> 1);
      end else begin
        ro_start = (pixel.row_offset > h_room) ? POS_W'(h_room) : POS_W'(pixel.row_offset);
        co_start = (pixel.col_offset > w_room) ? POS_W'(w_room) : POS_W'(pixel.col_offset);
      end
    end
  end

  // A start beat restarts the raster at the origin with fresh settings.
  assign r_cur      = pixel.image_start ? '0 : row_count;
  assign c_cur      = pixel.image_start ? '0 : col_count;
  assign ch_cur     = pixel.image_start ? '0 : chan_count;
  assign ro_cur     = pixel.image_start ? ro_start : latched_row_off;
  assign co_cur     = pixel.image_start ? co_start : latched_col_off;
  assign mirror_cur = pixel.image_start ? pixel.mirror_on : latched_mirror;
  assign raw_cur    = pixel.image_start ? pixel.raw_mode : latched_raw;

  // Raster advance: channel, then column, then row, wrapping at the end.
  always_comb begin
    row_next  = r_cur;
    col_next  = c_cur;
    chan_next = ch_cur;
    if (int'(ch_cur) + 1 >= int'(cfg.c_eff)) begin
      chan_next = '0;
      if (int'(c_cur) + 1 >= int'(cfg.w_eff)) begin
        col_next = '0;
        row_next = (int'(r_cur) + 1 >= int'(cfg.h_eff)) ? '0 : r_cur + POS_W'(1);
      end else begin
        col_next = c_cur + POS_W'(1);
      end
    end else begin
      chan_next = ch_cur + CH_W'(1);
    end
  end

  // Position state and latched image settings.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= '0;
      col_count       <= '0;
      chan_count      <= '0;
      latched_row_off <= '0;
      latched_col_off <= '0;
      latched_mirror  <= 1'b0;
      latched_raw     <= 1'b0;
    end else if (accept) begin
      row_count       <= row_next;
      col_count       <= col_next;
      chan_count      <= chan_next;
      latched_row_off <= ro_cur;
      latched_col_off <= co_cur;
      latched_mirror  <= mirror_cur;
      latched_raw     <= raw_cur;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.byte_val <= pixel.pixel_byte;
      s1.row      <= r_cur;
      s1.col      <= c_cur;
      s1.chan     <= ch_cur;
      s1.row_off  <= ro_cur;
      s1.col_off  <= co_cur;
      s1.mirror   <= mirror_cur;
      s1.raw      <= raw_cur;
    end
  end

endmodule

// File: hw/rtl/crmm_win.sv
module crmm_win (
  input  logic           clk,
  input  logic           rst,
  input  crmm_pkg::cfg_t cfg,
  input  logic           s1_valid,
  input  crmm_pkg::pos_t s1,
  output logic           s1_ready,
  output logic           s2_valid,
  output crmm_pkg::win_t s2,
  input  logic           s2_ready
);
  import crmm_pkg::*;

  logic [POS_W-1:0]         h;
  logic [POS_W-1:0]         w;
  logic                     hit;
  logic [DIM_W-1:0]         w_mirror;
  logic [POS_W-1:0]         col_dst;
  logic                     last;
  logic signed [DIFF_W-1:0] diff;
  logic [CHW_W-1:0]         chw;

  assign s1_ready = !s2_valid || s2_ready;

  // Window membership and position inside the window.
  assign h   = s1.row - s1.row_off;
  assign w   = s1.col - s1.col_off;
  assign hit = (s1.row >= s1.row_off) && (s1.col >= s1.col_off) &&
               (DIM_W'(h) < cfg.win_h) && (DIM_W'(w) < cfg.win_w) &&
               (int'(s1.chan) < int'(cfg.c_eff));

  assign w_mirror = cfg.win_w - DIM_W'(1) - DIM_W'(w);
  assign col_dst  = s1.mirror ? POS_W'(w_mirror) : w;

  assign last = (DIM_W'(h) == cfg.win_h - DIM_W'(1)) &&
                (DIM_W'(w) == cfg.win_w - DIM_W'(1)) &&
                (int'(s1.chan) == int'(cfg.c_eff) - 1);

  // Mean subtraction in Q8.4 and the plane-plus-row part of the address.
  assign diff = $signed({1'b0, s1.byte_val, MEAN_FRAC_W'(0)}) -
                $signed({1'b0, channel_mean(s1.chan, cfg)});
  assign chw  = CHW_W'(s1.chan) * CHW_W'(cfg.win_h) + CHW_W'(h);

  // Bytes outside the window are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2.byte_val <= s1.byte_val;
      s2.raw      <= s1.raw;
      s2.diff     <= diff;
      s2.chw      <= chw;
      s2.col_dst  <= col_dst;
      s2.last     <= last;
    end
  end

endmodule

// File: hw/rtl/crmm_norm.sv
module crmm_norm (
  input  logic           clk,
  input  logic           rst,
  input  crmm_pkg::cfg_t cfg,
  input  logic           s2_valid,
  input  crmm_pkg::win_t s2,
  output logic           s2_ready,
  crmm_result_if.source  result
);
  import crmm_pkg::*;

  logic                      s3_valid;
  logic                      s3_ready;
  prod_t                     s3;
  logic signed [PROD_W-1:0]  prod_full;
  logic [CHW_W+DIM_W-1:0]    addr_full;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [VALUE_W-1:0] value_next;

  assign s3_ready = !result.valid || result.ready;
  assign s2_ready = !s3_valid || s3_ready;

  // Scale multiply and the full planar address.
  assign prod_full = s2.diff * $signed({1'b0, cfg.scale});
  assign addr_full = s2.chw * cfg.win_w + (CHW_W + DIM_W)'(s2.col_dst);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      s3.byte_val <= s2.byte_val;
      s3.raw      <= s2.raw;
      s3.prod     <= prod_full;
      s3.addr     <= ADDR_W'(addr_full);
      s3.last     <= s2.last;
    end
  end

  // Drop four fraction bits, rounding to nearest with ties upward.
  assign rounded    = (s3.prod + $signed(PROD_W'(ROUND_BIAS))) >>> ROUND_SHIFT;
  assign value_next = s3.raw ? VALUE_W'({s3.byte_val, FRAC_W'(0)}) : rounded[VALUE_W-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s3_ready) begin
      result.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      result.out_addr  <= s3.addr;
      result.out_value <= value_next;
      result.out_last  <= s3.last;
    end
  end

endmodule

// File: hw/rtl/crmm_checker.sv
module crmm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pix_valid,
  input logic                             pix_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [crmm_pkg::ADDR_W-1:0]      res_addr,
  input logic signed [crmm_pkg::VALUE_W-1:0] res_value,
  input logic                             res_last
);
  import crmm_pkg::*;

  // A stalled result beat stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_addr) && $stable(res_value) && $stable(res_last))
    else $error("result payload changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // A fresh result beat must trace back to an accepted byte through the register stages.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_valid && pix_ready, 4))
    else $error("result beat without a byte accepted four cycles before");

  // With nothing waiting at the output, the pipeline drains and takes bytes.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pix_ready)
    else $error("byte refused while the output is empty");

endmodule

bind crop_mirror_mean_scale_chw_top crmm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixel.valid),
  .pix_ready (pixel.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_addr  (result.out_addr),
  .res_value (result.out_value),
  .res_last  (result.out_last)
);
